FILE: hdl/lir_pkg.sv
// Shared constants and types for the linear interpolation resampler.
`default_nettype none

package lir_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int STEP_W          = 21;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/linear_interp_resampler.sv
// Linear interpolation sample-rate converter, top level.
//
// Input stream (s_axis_*): one signed sample per transfer in tdata, tlast on the
// final sample of a block. Output stream (m_axis_*): one interpolated sample per
// transfer, tlast on the final output of the block, tuser on the last output
// caused by a given input. Output k of a block sits at source position
// k*phase_step; phase_step (Q5.16 by default) is written through
// phase_step_we / phase_step_wdata; the user must write it only while the
// block is idle, as the block does not enforce this. It is clamped to the
// range 1/32 .. 16. Sequencing: a transfer is taken in the idle state, then a
// loop (position check, multiply, output load) runs once per output through
// the one shared multiplier, plus one check to end the input and one more
// when the last sample opens the tail. The opening sample of a block, when not
// flagged last, only loads the sample history and returns to idle.
// tready is high only while idle; a waiting output register does not block it.
// When the receiver stalls, the sequencer holds in the output-load step.
// Reset (rst, synchronous) empties the output, restarts the block at position
// zero and sets phase_step to 1.0.
`default_nettype none

module linear_interp_resampler #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF,
  localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      phase_step_we,
  input  wire logic [lir_pkg::STEP_W-1:0] phase_step_wdata,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [TDATA_W-1:0]        s_axis_tdata,   // sample_in, zero pad
  input  wire logic                      s_axis_tlast,   // last_sample
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [TDATA_W-1:0]             m_axis_tdata,   // sample_out, zero pad
  output logic                           m_axis_tlast,   // block_end
  output logic                           m_axis_tuser    // run_end
);

  import lir_pkg::*;

  localparam int POS_W = FRAC_BITS + 6;
  localparam logic [POS_W-1:0] ONE_POS = {5'b0, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [POS_W-1:0] TWO_POS = {4'b0, 1'b1, {(FRAC_BITS+1){1'b0}}};
  localparam logic [31:0] STEP_MIN = 32'(1) << (FRAC_BITS - 5);
  localparam logic [31:0] STEP_MAX = 32'(1) << (FRAC_BITS + 4);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(32'(1) << FRAC_BITS);

  state_t state, state_next;

  logic [STEP_W-1:0]             step_reg;
  logic [POS_W-1:0]              eff_step;
  logic [POS_W-1:0]              pos;
  logic [POS_W-1:0]              pos_step;
  logic                          have_prev;
  logic                          tail;
  logic                          last_q;
  logic signed [SAMPLE_BITS-1:0] prev;
  logic signed [SAMPLE_BITS-1:0] cur;
  logic signed [SAMPLE_BITS-1:0] lerp_y;

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_run_end;
  logic                          out_block_end;

  logic take;
  logic pos_lt_one;
  logic mul_en;
  logic emit_go;
  logic run_end;

  // clamp the step to 1/32 .. 16
  always_comb begin
    if (32'(step_reg) < STEP_MIN) begin
      eff_step = STEP_MIN[POS_W-1:0];
    end else if (32'(step_reg) > STEP_MAX) begin
      eff_step = STEP_MAX[POS_W-1:0];
    end else begin
      eff_step = POS_W'(step_reg);
    end
  end

  assign pos_lt_one = (pos < ONE_POS);
  assign pos_step   = pos + eff_step;
  assign take       = s_axis_tvalid && s_axis_tready;

  // last output of this input: the loop leaves, and no tail follows
  always_comb begin
    if (tail) begin
      run_end = (pos_step >= ONE_POS);
    end else begin
      run_end = (pos_step >= ONE_POS) && !(last_q && (pos_step < TWO_POS));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && (have_prev || s_axis_tlast)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (pos_lt_one) begin
          state_next = ST_MUL;
        end else if (!tail && last_q) begin
          state_next = ST_CHECK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || m_axis_tready) begin
          state_next = ST_CHECK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mul_en        = 1'b0;
    emit_go       = 1'b0;
    case (state)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_MUL:   mul_en        = 1'b1;
      ST_EMIT:  emit_go       = !out_valid || m_axis_tready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg <= STEP_RESET;
    end else if (phase_step_we) begin
      step_reg <= phase_step_wdata;
    end
  end

  // block position and sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      pos       <= '0;
      tail      <= 1'b0;
    end else begin
      if (take) begin
        if (!have_prev) begin
          have_prev <= 1'b1;
          tail      <= s_axis_tlast;
        end else begin
          tail      <= 1'b0;
        end
      end else if (state == ST_CHECK && !pos_lt_one) begin
        if (!tail) begin
          pos <= pos - ONE_POS;
          if (last_q) begin
            tail <= 1'b1;
          end
        end else begin
          // end of block: start the next one at position zero
          have_prev <= 1'b0;
          pos       <= '0;
          tail      <= 1'b0;
        end
      end else if (emit_go) begin
        pos <= pos_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur    <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
      last_q <= s_axis_tlast;
      if (!have_prev) begin
        prev <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
      end
    end else if (state == ST_CHECK && !pos_lt_one && !tail) begin
      prev <= cur;
    end
  end

  lir_lerp_unit #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lerp (
    .clk    (clk),
    .mul_en (mul_en),
    .a      (prev),
    .b      (cur),
    .frac   (pos[FRAC_BITS-1:0]),
    .y      (lerp_y)
  );

  // output register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_sample    <= lerp_y;
      out_run_end   <= run_end;
      out_block_end <= run_end && last_q;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'($unsigned(out_sample));
  assign m_axis_tlast  = out_block_end;
  assign m_axis_tuser  = out_run_end;

  a_block_end_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("block end without run end");

  a_pos_zero_between_blocks: assert property (@(posedge clk) disable iff (rst)
    !have_prev |-> pos == '0)
    else $error("position not cleared between blocks");

  a_tail_repeats_sample: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) && tail |-> prev == cur)
    else $error("tail output would not repeat the last sample");

  a_emit_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |=> (state == ST_EMIT) && $past(pos_lt_one))
    else $error("multiply without a position below one");

endmodule

`default_nettype wire

FILE: hdl/lir_lerp_unit.sv
// Shared interpolation unit: registered multiply, then add and truncate toward zero.
`default_nettype none

module lir_lerp_unit #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          mul_en,
  input  wire logic signed [SAMPLE_BITS-1:0] a,
  input  wire logic signed [SAMPLE_BITS-1:0] b,
  input  wire logic        [FRAC_BITS-1:0]   frac,
  output logic signed      [SAMPLE_BITS-1:0] y
);

  import lir_pkg::*;

  localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          acc;
  logic        [PW-1:0]          acc_adj;

  assign diff   = $signed({b[SAMPLE_BITS-1], b}) - $signed({a[SAMPLE_BITS-1], a});
  assign frac_s = $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= diff * frac_s;
    end
  end

  // a*(1-f) + b*f rewritten as a*ONE + (b-a)*f
  assign acc = PW'($signed({a, {FRAC_BITS{1'b0}}})) + prod;

  // bias negatives so the shift truncates toward zero
  always_comb begin
    if (acc[PW-1]) begin
      acc_adj = acc + PW'({FRAC_BITS{1'b1}});
    end else begin
      acc_adj = acc;
    end
  end

  assign y = acc_adj[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];

endmodule

`default_nettype wire

FILE: sim/linear_interp_resampler_test.sv
// Self-checking testbench for the linear interpolation resampler.

module linear_interp_resampler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = lir_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC_W = lir_pkg::FRAC_BITS_DEF;
  localparam int STEP_W = lir_pkg::STEP_W;
  localparam int TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned UNIT_POS = 1 << FRAC_W;
  localparam int unsigned STEP_FLOOR = UNIT_POS >> 5;
  localparam int unsigned STEP_CEIL = UNIT_POS << 4;
  localparam int unsigned STEP_ALL_ONES = (1 << STEP_W) - 1;
  localparam int RUN_CAP = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic run_end;
    logic block_end;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic phase_step_we = 1'b0;
  logic [STEP_W-1:0] phase_step_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;   // sample_in
  logic s_axis_tlast = 1'b0;               // last_sample
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [TDATA_W-1:0] m_axis_tdata;        // sample_out
  logic m_axis_tlast;                      // block_end
  logic m_axis_tuser;                      // run_end

  linear_interp_resampler u_top (
    .clk              (clk),
    .rst              (rst),
    .phase_step_we    (phase_step_we),
    .phase_step_wdata (phase_step_wdata),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .m_axis_tuser     (m_axis_tuser)
  );

  // Resampler state as the testbench sees it
  logic [STEP_W-1:0] step_reg = STEP_W'(UNIT_POS);
  logic signed [SAMPLE_W-1:0] held_sample = '0;
  logic block_open = 1'b0;
  int unsigned next_pos = 0;
  out_beat_t pending_beats[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int samples_sent = 0;
  int blocks_sent = 0;
  int step_writes = 0;
  int beats_expected = 0;
  int beats_checked = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t: mismatch on %s after %0d results: got %0d, expected %0d",
               $realtime, what, beats_checked, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected result", int'($signed(m_axis_tdata[SAMPLE_W-1:0])), 0);
      end else begin
        want = pending_beats.pop_front();
        if ($signed(m_axis_tdata[SAMPLE_W-1:0]) != want.sample)
          report_mismatch("sample_out", int'($signed(m_axis_tdata[SAMPLE_W-1:0])),
                          int'(want.sample));
        if (m_axis_tuser !== want.run_end)
          report_mismatch("run_end", int'(m_axis_tuser), int'(want.run_end));
        if (m_axis_tlast !== want.block_end)
          report_mismatch("block_end", int'(m_axis_tlast), int'(want.block_end));
      end
      beats_checked++;
    end
  end

  // s0*(1-f) + s1*f, quotient truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] blend(input logic signed [SAMPLE_W-1:0] s0,
                                                        input logic signed [SAMPLE_W-1:0] s1,
                                                        input int unsigned frac);
    longint acc;
    acc = longint'(s0) * longint'(UNIT_POS - frac) + longint'(s1) * longint'(frac);
    return SAMPLE_W'(acc / longint'(UNIT_POS));
  endfunction

  task automatic predict_outputs(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
    int unsigned step;
    out_beat_t run[$];
    out_beat_t beat;
    step = step_reg;
    if (step < STEP_FLOOR) step = STEP_FLOOR;
    else if (step > STEP_CEIL) step = STEP_CEIL;
    beat = '0;
    if (block_open) begin
      while (next_pos < UNIT_POS && run.size() < RUN_CAP) begin
        beat.sample = blend(held_sample, smp, next_pos);
        run.insert(run.size(), beat);
        next_pos += step;
      end
      next_pos -= UNIT_POS;
    end
    held_sample = smp;
    block_open = 1'b1;
    // repeat the final sample up to the block length
    if (lst) begin
      while (next_pos < UNIT_POS && run.size() < RUN_CAP) begin
        beat.sample = smp;
        run.insert(run.size(), beat);
        next_pos += step;
      end
      block_open = 1'b0;
      next_pos = 0;
    end
    if (run.size() > 0) begin
      run[run.size()-1].run_end = 1'b1;
      run[run.size()-1].block_end = lst;
    end
    foreach (run[i]) pending_beats.insert(pending_beats.size(), run[i]);
    beats_expected += run.size();
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= TDATA_W'(smp);
    s_axis_tlast <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_outputs(smp, lst);
    samples_sent++;
    if (lst) blocks_sent++;
  endtask

  // Drop valid, wait for every expected transfer, then let a zero-output input finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] value);
    wait_idle();
    phase_step_we <= 1'b1;
    phase_step_wdata <= value;
    @(posedge clk);
    step_reg = value;
    step_writes++;
    phase_step_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [STEP_W-1:0] random_step();
    case ($urandom_range(9))
      0: return STEP_W'($urandom_range(STEP_FLOOR - 1));
      1: return STEP_W'($urandom_range(STEP_FLOOR, UNIT_POS / 2 - 1));
      2: return STEP_W'($urandom_range(2 * UNIT_POS + 1, STEP_CEIL));
      3: return STEP_W'($urandom_range(STEP_CEIL + 1, STEP_ALL_ONES));
      4: return STEP_W'(UNIT_POS);
      default: return STEP_W'($urandom_range(UNIT_POS / 2, 2 * UNIT_POS));
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7))
      0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      2: return SAMPLE_W'($urandom_range(3)) - SAMPLE_W'(2);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Reset value of the step is 1.0: samples come out one input late
  task automatic test_passthrough();
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);
    wait_idle();
  endtask

  task automatic test_single_sample_block();
    send_sample(-16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b1);
    wait_idle();
  endtask

  // Half steps between opposite extremes exercise truncation of negative sums
  task automatic test_interp_extremes();
    write_step(STEP_W'(UNIT_POS / 2));
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh8000, 1'b1);
    wait_idle();
  endtask

  task automatic test_step_clamp();
    write_step('0);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b1);
    write_step(STEP_W'(STEP_FLOOR - 1));
    send_sample(16'sd7, 1'b1);
    write_step(STEP_W'(STEP_ALL_ONES));
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd3, 1'b1);
    write_step(STEP_W'(STEP_CEIL));
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd6, 1'b1);
    wait_idle();
  endtask

  // Step 3.0 over three samples: the flagged sample yields nothing
  task automatic test_empty_tail();
    write_step(STEP_W'(3 * UNIT_POS));
    send_sample(16'sd1000, 1'b0);
    send_sample(16'sd2000, 1'b0);
    send_sample(16'sd3000, 1'b1);
    send_sample(-16'sd5, 1'b1);
    wait_idle();
  endtask

  task automatic test_step_change_mid_block();
    send_idle_pct = 40;
    stall_pct = 40;
    write_step(STEP_W'(UNIT_POS));
    send_sample(16'sd10, 1'b0);
    send_sample(16'sd20, 1'b0);
    write_step(STEP_W'(UNIT_POS + UNIT_POS / 2));
    send_sample(16'sd30, 1'b0);
    send_sample(16'sd40, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_blocks(input int idle_pct, input int stall, input int n_items);
    int sent;
    int len;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) write_step(random_step());
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(19) == 0) write_step(random_step());
        // hold the sender until the output side has fully drained
        if ($urandom_range(24) == 0) wait_idle();
        send_sample(random_sample(), i == len - 1);
      end
      sent += len;
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough();
    test_single_sample_block();
    test_interp_extremes();
    test_step_clamp();
    test_empty_tail();
    test_step_change_mid_block();
    test_random_blocks(0, 0, 30);
    test_random_blocks(56, 0, 30);
    test_random_blocks(0, 56, 30);
    test_random_blocks(25, 25, 30);
    wait_idle();
    $display("Sent %0d samples in %0d blocks across %0d step writes; checked %0d of %0d outputs.",
             samples_sent, blocks_sent, step_writes, beats_checked, beats_expected);
    $display("Covered reset pass-through, clamped steps, empty tails, mid-block step changes");
    $display("and four mixes of sender gaps and receiver back-pressure.");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: linear_interp_resampler.f
hdl/lir_pkg.sv
hdl/lir_lerp_unit.sv
hdl/linear_interp_resampler.sv
sim/linear_interp_resampler_test.sv
